>>> rtl/core/coled_pkg.sv
// shared constants, types and color/fade functions for the center-out led animator
package coled_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int PIX_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    localparam int CH_W       = 8;
    localparam int ROW_W      = 6 * CH_W;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [3*CH_W-1:0] rgb_t;

    // opcodes of the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;

    // register indexes on the config port
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] REG_FADE_RATE   = 2'd1;
    localparam logic [1:0] REG_STEP_DIVIDE = 2'd2;
    localparam logic [1:0] REG_PIXEL_COUNT = 2'd3;

    localparam logic [7:0] BRIGHTNESS_RST  = 8'd250;
    localparam logic [7:0] FADE_RATE_RST   = 8'd30;
    localparam logic [7:0] STEP_DIVIDE_RST = 8'd4;
    localparam logic [6:0] PIXEL_COUNT_RST = 7'd64;
    localparam logic [7:0] COLOR_RST       = 8'd1;
    localparam logic [7:0] COLOR_LAST      = 8'd8;
    localparam logic [7:0] COLOR_PLAIN_MAX = 8'd7;

    // bits 0..2 of a color code enable r, g, b at the given level
    function automatic rgb_t gate_color(input logic [2:0] code, input chan_t level);
        rgb_t res;
        res = {(code[2] ? level : '0), (code[1] ? level : '0), (code[0] ? level : '0)};
        return res;
    endfunction

    // move one channel toward its setpoint by at most rate, no overshoot
    function automatic chan_t approach(input chan_t cur, input chan_t tgt, input chan_t rate);
        logic [CH_W:0] up;
        logic [CH_W:0] lim;
        chan_t         res;
        up  = {1'b0, cur} + {1'b0, rate};
        lim = {1'b0, tgt} + {1'b0, rate};
        if (cur < tgt)
        begin
            res = (up > {1'b0, tgt}) ? tgt : up[CH_W-1:0];
        end
        else if (cur > tgt)
        begin
            res = ({1'b0, cur} < lim) ? tgt : cur - rate;
        end
        else
        begin
            res = cur;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/center_out_led_fade_animator_core.sv
// center-out led fade animator: config port, sequencer, pixel memory and fade unit
// A frame tick transaction (opcode 0) walks every pixel in use, pixel 0 upward, and emits one
// output transaction per pixel with last set on the final one. Each pixel passes S_READ, which
// reads its row (setpoint and current color) from the single-port pixel memory, then S_CALC,
// which paints the ring setpoint, runs the shared fade unit, writes the row back and loads the
// output register; S_CALC holds while the output register is full and stalled. The
// block stalls its input for the whole walk. Set color and next color take effect in the
// accepting cycle and produce no output. Pixel memory rows read as zero until first written,
// so no clearing pass runs after reset. Registers: brightness at 0x0, fade_rate at 0x4,
// step_divide at 0x8, pixel_count at 0xC; write them only while the block is idle.
module center_out_led_fade_animator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [coled_pkg::ADDR_W-1:0]  paddr,
    input  logic [coled_pkg::DATA_W-1:0]  pwdata,
    output logic [coled_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [7:0]                    new_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [coled_pkg::PIX_W-1:0]   pixel_index,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic                          last
);
    import coled_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    logic [7:0]       brightness_reg;
    logic [7:0]       fade_rate_reg;
    logic [7:0]       step_divide_reg;
    logic [6:0]       pixel_count_reg;

    logic [1:0]       state_reg, state_next;
    logic [PIX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg;
    logic [PIX_W-1:0] ring_step_reg;
    logic [7:0]       tick_count_reg;
    logic             restart_reg;
    logic [7:0]       color_code_reg;

    logic             expand_reg;
    logic [PIX_W-1:0] reach_reg;
    logic             rainbow_reg;

    logic [ROW_W-1:0] pix_mem [MAX_PIXELS];
    logic             row_vld_reg [MAX_PIXELS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_index_reg;
    rgb_t             out_rgb_reg;
    logic             last_reg;

    logic             cfg_wr;
    logic             in_acc;
    logic             out_free;
    logic             step_now;

    logic [CNT_W-1:0] n_used;
    logic [CNT_W-1:0] center_now;
    logic [CNT_W-1:0] center;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] ring_dist;
    logic             paint;
    logic [2:0]       paint_code;
    logic [ROW_W-1:0] row;
    rgb_t             tgt_rgb;
    rgb_t             cur_rgb;
    rgb_t             new_rgb;
    logic             is_last;
    logic [7:0]       tick_inc;
    logic [7:0]       color_inc;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_BRIGHTNESS:  prdata = {{(DATA_W-8){1'b0}}, brightness_reg};
            REG_FADE_RATE:   prdata = {{(DATA_W-8){1'b0}}, fade_rate_reg};
            REG_STEP_DIVIDE: prdata = {{(DATA_W-8){1'b0}}, step_divide_reg};
            REG_PIXEL_COUNT: prdata = {{(DATA_W-7){1'b0}}, pixel_count_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= BRIGHTNESS_RST;
            fade_rate_reg   <= FADE_RATE_RST;
            step_divide_reg <= STEP_DIVIDE_RST;
            pixel_count_reg <= PIXEL_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BRIGHTNESS:  brightness_reg  <= pwdata[7:0];
                REG_FADE_RATE:   fade_rate_reg   <= pwdata[7:0];
                REG_STEP_DIVIDE: step_divide_reg <= pwdata[7:0];
                REG_PIXEL_COUNT: pixel_count_reg <= pwdata[6:0];
                default:         brightness_reg  <= brightness_reg;
            endcase
        end
    end

    // input side
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid & ~in_stall;

    always_comb
    begin
        if (pixel_count_reg == 7'd0)
        begin
            n_used = CNT_W'(1);
        end
        else if ({1'b0, pixel_count_reg} > 8'(MAX_PIXELS))
        begin
            n_used = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            n_used = CNT_W'(pixel_count_reg);
        end
    end

    assign center_now = n_used >> 1;
    assign tick_inc   = tick_count_reg + 8'd1;
    assign step_now   = (tick_inc >= step_divide_reg);
    assign color_inc  = color_code_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_step_reg  <= '0;
            tick_count_reg <= '0;
            restart_reg    <= 1'b0;
            color_code_reg <= COLOR_RST;
            expand_reg     <= 1'b0;
            reach_reg      <= '0;
            rainbow_reg    <= 1'b0;
            n_reg          <= CNT_W'(MAX_PIXELS);
        end
        else if (in_acc)
        begin
            case (opcode)
                OP_SET:
                begin
                    color_code_reg <= new_color;
                    ring_step_reg  <= '0;
                    restart_reg    <= 1'b1;
                end
                OP_NEXT:
                begin
                    color_code_reg <= (color_inc > COLOR_LAST) ? COLOR_RST : color_inc;
                end
                OP_TICK:
                begin
                    n_reg       <= n_used;
                    expand_reg  <= step_now;
                    // the walk paints with the sweep as it stood before this step
                    reach_reg   <= ring_step_reg;
                    rainbow_reg <= ~restart_reg & (color_code_reg > COLOR_PLAIN_MAX);
                    if (step_now)
                    begin
                        tick_count_reg <= '0;
                        if (CNT_W'(ring_step_reg) < center_now)
                        begin
                            ring_step_reg <= ring_step_reg + PIX_W'(1);
                        end
                        else if (restart_reg)
                        begin
                            ring_step_reg <= '0;
                            restart_reg   <= 1'b0;
                        end
                    end
                    else
                    begin
                        tick_count_reg <= tick_inc;
                    end
                end
                default:
                begin
                    color_code_reg <= color_code_reg;
                end
            endcase
        end
    end

    // pixel walk sequencer
    assign out_free = ~out_valid_reg | ~out_stall;
    assign idx_ext  = CNT_W'(idx_reg);
    assign is_last  = ((idx_ext + CNT_W'(1)) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (opcode == OP_TICK))
                begin
                    state_next = S_READ;
                    idx_next   = '0;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (out_free)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                        idx_next   = idx_reg + PIX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // ring paint and shared fade unit
    assign center    = n_reg >> 1;
    assign ring_dist = (idx_ext >= center) ? (idx_ext - center) : (center - idx_ext);
    assign paint     = expand_reg & (ring_dist <= CNT_W'(reach_reg));
    assign paint_code = ((ring_dist != '0) && rainbow_reg) ? ring_dist[2:0] : color_code_reg[2:0];

    assign row     = rd_vld_reg ? rd_data_reg : '0;
    assign tgt_rgb = paint ? gate_color(paint_code, brightness_reg) : row[ROW_W-1:3*CH_W];
    assign cur_rgb = row[3*CH_W-1:0];

    assign new_rgb = {approach(cur_rgb[3*CH_W-1:2*CH_W], tgt_rgb[3*CH_W-1:2*CH_W], fade_rate_reg),
                      approach(cur_rgb[2*CH_W-1:CH_W],   tgt_rgb[2*CH_W-1:CH_W],   fade_rate_reg),
                      approach(cur_rgb[CH_W-1:0],        tgt_rgb[CH_W-1:0],        fade_rate_reg)};

    // pixel memory: row is {setpoint, current}
    always_ff @(posedge clk)
    begin
        rd_data_reg <= pix_mem[idx_reg];
        if ((state_reg == S_CALC) && out_free)
        begin
            pix_mem[idx_reg] <= {tgt_rgb, new_rgb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXELS; i++)
            begin
                row_vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= row_vld_reg[idx_reg];
            if ((state_reg == S_CALC) && out_free)
            begin
                row_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_CALC) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CALC) && out_free)
        begin
            pixel_index_reg <= idx_reg;
            out_rgb_reg     <= new_rgb;
            last_reg        <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = out_rgb_reg[CH_W-1:0];
    assign green       = out_rgb_reg[2*CH_W-1:CH_W];
    assign blue        = out_rgb_reg[3*CH_W-1:2*CH_W];
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (opcode == OP_TICK) |=> state_reg == S_READ)
        else $error("frame tick did not start the pixel walk");

    a_out_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_CALC)
        else $error("output loaded outside the calc step");

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(ring_step_reg) <= CNT_W'(MAX_PIXELS / 2))
        else $error("ring step past strip half");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> CNT_W'(pixel_index_reg) < n_reg)
        else $error("emitted pixel index beyond pixels in use");
`endif

endmodule

>>> sim/center_out_led_fade_animator_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the center-out led fade animator core
module center_out_led_fade_animator_core_tb;
    import coled_pkg::*;

    localparam int         CLK_HALF      = 4;
    localparam int         RESET_CYCLES  = 8;
    localparam int         MAX_REPORTS   = 10;
    localparam int         RAND_ITEMS    = 280;
    localparam int         IDLE_PCT      = 23;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 400;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [7:0] WRAP_COLOR    = 8'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             lst;
    } pixel_txn_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode    = OP_TICK;
    logic [7:0]        new_color = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PIX_W-1:0]  pixel_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;

    center_out_led_fade_animator_core DUT (.*);

    // predicted block state
    logic [7:0] pm_brightness;
    logic [7:0] pm_fade;
    logic [7:0] pm_divide;
    logic [6:0] pm_count;
    logic [7:0] cur_lvl [MAX_PIXELS][3];
    logic [7:0] tgt_lvl [MAX_PIXELS][3];
    logic [5:0] sweep_ring;
    logic [7:0] frame_div;
    logic       restarting;
    logic [7:0] color_sel;

    pixel_txn_t expected_pixels [$];

    int  mismatches  = 0;
    int  n_checked   = 0;
    int  n_frames    = 0;
    int  n_color_ops = 0;
    int  n_reg_wr    = 0;
    int  n_phases    = 0;
    bit  quiet       = 1'b0;
    bit  hold_armed  = 1'b0;

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    function automatic void reset_model();
        pm_brightness = BRIGHTNESS_RST;
        pm_fade       = FADE_RATE_RST;
        pm_divide     = STEP_DIVIDE_RST;
        pm_count      = PIXEL_COUNT_RST;
        for (int i = 0; i < MAX_PIXELS; i++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                cur_lvl[i][ch] = 8'd0;
                tgt_lvl[i][ch] = 8'd0;
            end
        end
        sweep_ring = '0;
        frame_div  = '0;
        restarting = 1'b0;
        color_sel  = COLOR_RST;
    endfunction

    function automatic rgb_t enable_mask(logic [7:0] code);
        rgb_t c;
        c[7:0]   = code[0] ? pm_brightness : 8'd0;
        c[15:8]  = code[1] ? pm_brightness : 8'd0;
        c[23:16] = code[2] ? pm_brightness : 8'd0;
        return c;
    endfunction

    // pixels outside the strip are silently skipped
    function automatic void paint(int idx, int n, rgb_t shade);
        if (idx >= 0 && idx < n)
        begin
            tgt_lvl[idx][0] = shade[7:0];
            tgt_lvl[idx][1] = shade[15:8];
            tgt_lvl[idx][2] = shade[23:16];
        end
    endfunction

    function automatic logic [7:0] fade_toward(logic [7:0] now_lvl, logic [7:0] goal);
        int c;
        int t;
        int r;
        c = now_lvl;
        t = goal;
        r = pm_fade;
        if (c < t)
        begin
            return (c + r > t) ? goal : 8'(c + r);
        end
        if (c > t)
        begin
            return (c < t + r) ? goal : 8'(c - r);
        end
        return now_lvl;
    endfunction

    function automatic void predict_frame();
        int         n;
        int         center;
        rgb_t       shade;
        pixel_txn_t px;
        n = (pm_count == 0) ? 1 : ((pm_count > MAX_PIXELS) ? MAX_PIXELS : int'(pm_count));
        frame_div = frame_div + 8'd1;
        if (frame_div >= pm_divide)
        begin
            frame_div = 8'd0;
            center = n / 2;
            shade = enable_mask(color_sel);
            paint(center, n, shade);
            for (int k = 0; k < int'(sweep_ring); k++)
            begin
                // rainbow rings only outside the restart sweep
                if (!restarting && color_sel > COLOR_PLAIN_MAX)
                begin
                    shade = enable_mask(8'(k + 1));
                end
                paint(center + k + 1, n, shade);
                paint(center - k - 1, n, shade);
            end
            if (int'(sweep_ring) < center)
            begin
                sweep_ring = sweep_ring + 6'd1;
            end
            else if (restarting)
            begin
                sweep_ring = '0;
                restarting = 1'b0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                cur_lvl[i][ch] = fade_toward(cur_lvl[i][ch], tgt_lvl[i][ch]);
            end
            px.pix   = PIX_W'(i);
            px.red   = cur_lvl[i][0];
            px.green = cur_lvl[i][1];
            px.blue  = cur_lvl[i][2];
            px.lst   = (i + 1 == n);
            expected_pixels.push_back(px);
        end
    endfunction

    function automatic void apply_txn(logic [1:0] op, logic [7:0] color);
        case (op)
            OP_TICK:
            begin
                predict_frame();
                n_frames++;
            end
            OP_SET:
            begin
                color_sel  = color;
                sweep_ring = '0;
                restarting = 1'b1;
                n_color_ops++;
            end
            OP_NEXT:
            begin
                color_sel = color_sel + 8'd1;
                if (color_sel > COLOR_LAST)
                begin
                    color_sel = WRAP_COLOR;
                end
                n_color_ops++;
            end
            default:
            begin
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_pixels
        pixel_txn_t got;
        pixel_txn_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{pixel_index, red, green, blue, last};
            if (expected_pixels.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected pixel transaction idx=%0d rgb=%02h_%02h_%02h",
                                        got.pix, got.red, got.green, got.blue));
            end
            else
            begin
                want = expected_pixels.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    flag_mismatch($sformatf({"expected idx=%0d rgb=%02h_%02h_%02h last=%0b, ",
                                             "got idx=%0d rgb=%02h_%02h_%02h last=%0b"},
                                            want.pix, want.red, want.green, want.blue, want.lst,
                                            got.pix, got.red, got.green, got.blue, got.lst));
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    initial
    begin : rx_side
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                out_stall <= 1'b1;
                held--;
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BRIGHTNESS:  pm_brightness = val;
            REG_FADE_RATE:   pm_fade = val;
            REG_STEP_DIVIDE: pm_divide = val;
            REG_PIXEL_COUNT: pm_count = val[6:0];
            default:         ;
        endcase
        n_reg_wr++;
    endtask

    task automatic send_txn(logic [1:0] op, logic [7:0] color);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        new_color <= color;
        do @(posedge clk); while (!(in_valid && !in_stall));
        apply_txn(op, color);
    endtask

    // drop valid, wait for every expected pixel, then let the walk finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        int p;
        p = $urandom_range(9);
        if (p == 0)
        begin
            return 8'd0;
        end
        if (p == 1)
        begin
            return 8'd255;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_count();
        int p;
        p = $urandom_range(19);
        case (p)
            0:       return 8'd0;
            1:       return 8'd64;
            2:       return 8'd127;
            3:       return 8'($urandom_range(127));
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic test_reset_defaults();
        repeat (4) send_txn(OP_TICK, 8'd0);
    endtask

    // one-pixel strip, divide of zero, fastest fade, full brightness
    task automatic test_config_extremes();
        wait_idle();
        write_reg(REG_BRIGHTNESS, 8'd255);
        write_reg(REG_FADE_RATE, 8'd255);
        write_reg(REG_STEP_DIVIDE, 8'd0);
        write_reg(REG_PIXEL_COUNT, 8'd0);
        send_txn(OP_SET, 8'd7);
        send_txn(OP_TICK, 8'd0);
        send_txn(OP_TICK, 8'd0);
    endtask

    // restart sweep runs off the end of an even strip, then rainbow rings
    task automatic test_even_strip_rainbow();
        wait_idle();
        write_reg(REG_BRIGHTNESS, 8'd200);
        write_reg(REG_STEP_DIVIDE, 8'd1);
        write_reg(REG_PIXEL_COUNT, 8'd4);
        send_txn(OP_SET, 8'd200);
        repeat (5) send_txn(OP_TICK, 8'd0);
    endtask

    // next-color wrap, unused opcode, frozen fade and oversized strip
    task automatic test_color_codes();
        wait_idle();
        write_reg(REG_FADE_RATE, 8'd0);
        write_reg(REG_PIXEL_COUNT, 8'd127);
        write_reg(REG_STEP_DIVIDE, 8'd255);
        send_txn(OP_SET, 8'd255);
        send_txn(OP_NEXT, 8'd0);
        send_txn(OP_NEXT, 8'd255);
        send_txn(OP_SET, 8'd8);
        send_txn(OP_NEXT, 8'd0);
        send_txn(OP_UNUSED, 8'd170);
        send_txn(OP_TICK, 8'd85);
    endtask

    // receiver holds off while frame ticks keep coming
    task automatic test_output_hold();
        wait_idle();
        write_reg(REG_FADE_RATE, 8'd40);
        write_reg(REG_STEP_DIVIDE, 8'd1);
        write_reg(REG_PIXEL_COUNT, 8'd64);
        hold_armed = 1'b1;
        repeat (4) send_txn(OP_TICK, 8'd0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int         sent;
        int         len;
        int         pick;
        logic [1:0] op;
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            wait_idle();
            quiet = (n_phases == 2);
            write_reg(REG_BRIGHTNESS, pick_level());
            write_reg(REG_FADE_RATE, pick_level());
            write_reg(REG_STEP_DIVIDE,
                      ($urandom_range(9) == 0) ? pick_level() : 8'($urandom_range(1, 3)));
            write_reg(REG_PIXEL_COUNT, pick_count());
            // most phases start a fresh sweep, then mostly ticks
            if ($urandom_range(3) != 0)
            begin
                send_txn(OP_SET, 8'($urandom_range(255)));
                sent++;
            end
            len = $urandom_range(15, 40);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    op = OP_TICK;
                end
                else if (pick < 82)
                begin
                    op = OP_SET;
                end
                else if (pick < 94)
                begin
                    op = OP_NEXT;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                send_txn(op, 8'($urandom_range(255)));
                sent++;
            end
            n_phases++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_even_strip_rainbow();
        test_color_codes();
        test_output_hold();
        test_random_phases();
        wait_idle();
        repeat (4 * MAX_PIXELS) @(posedge clk);
        $display("covered %0d frame ticks and %0d color events, %0d register writes, %0d phases",
                 n_frames, n_color_ops, n_reg_wr, n_phases);
        $display("checked %0d pixel transactions, %0d mismatches, %0d still pending",
                 n_checked, mismatches, expected_pixels.size());
        if (mismatches == 0 && expected_pixels.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/coled_pkg.sv
rtl/core/center_out_led_fade_animator_core.sv
sim/center_out_led_fade_animator_core_tb.sv
